FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of the bitmap block.
// Depends on nothing; included by name from files that assert.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define BSFN_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BSFN_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/bsfn_pkg.sv
// Package for the bitmap set with find-next: sizes, request codes, states.
// Depends on nothing; used by every module of the block but bsfn_ram.
`timescale 1ns / 1ps

package bsfn_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int WORD_BITS    = 64;
  localparam int NUM_WORDS    = (MAX_ELEMENTS + WORD_BITS - 1) / WORD_BITS;

  localparam int WORD_W = $clog2(WORD_BITS);
  localparam int ADDR_W = $clog2(NUM_WORDS);
  localparam int ELEM_W = 10;
  localparam int CAP_W  = 11;
  localparam int CNT_W  = 11;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_TEST   = 2'd2,
    OP_FIND   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

FILE: hw/rtl/bsfn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module bsfn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/bsfn_word_scan.sv
// Shared word unit: masks off bits below a start position and finds the lowest set bit.
// Depends on bsfn_pkg.
`timescale 1ns / 1ps

module bsfn_word_scan (
  input  logic [bsfn_pkg::WORD_BITS-1:0] word,
  input  logic [bsfn_pkg::WORD_W-1:0]    start,
  output logic                           any,
  output logic [bsfn_pkg::WORD_W-1:0]    pos
);

  logic [bsfn_pkg::WORD_BITS-1:0] masked;
  logic [bsfn_pkg::WORD_BITS-1:0] lowest;

  // Isolate the lowest set bit, then encode the one-hot result.
  assign masked = word & ({bsfn_pkg::WORD_BITS{1'b1}} << start);
  assign lowest = masked & (~masked + bsfn_pkg::WORD_BITS'(1));
  assign any    = |masked;

  always_comb begin
    pos = '0;
    for (int i = 0; i < bsfn_pkg::WORD_BITS; i++) begin
      if (lowest[i]) begin
        pos = pos | bsfn_pkg::WORD_W'(i);
      end
    end
  end

endmodule

FILE: hw/rtl/bitmap_set_find_next.sv
// Insert, erase and test go from accept through the scan and done states to the output
// register; a refused word skips the scan state, and find-next stays in the scan state
// for each bitmap word it reads (1 to 16). Words are taken one at a time: the input is
// ready again once the result is loaded into the output register. A full output
// register holds the sequencer.
// Reset (synchronous, rst_n low): bitmap empty, member count zero, capacity 1024.
`timescale 1ns / 1ps

// Top level of the membership bitmap. Depends on bsfn_pkg, bsfn_ram and bsfn_word_scan.
//
// The bitmap lives in a 16 x 64 RAM. A valid bit per RAM row stands in for clearing
// the RAM at reset: a row that was never written reads as all zero. A small sequencer
// drives one shared word unit: on accept it issues the read of the word holding the
// element, and in the scan state it evaluates the word that comes back. Insert and
// erase write the modified word back in that same cycle. Find-next walks forward one
// word per cycle until it sees a set bit or reaches the last word below the limit.
//
// The finished result sits in an output register, so a new input word can be taken
// while a previous result still waits for out_ready.

module bitmap_set_find_next (
  input  logic                         clk,
  input  logic                         rst_n,
  // Configuration: capacity register.
  input  logic                         cfg_wr_en,
  input  logic [bsfn_pkg::CAP_W-1:0]   cfg_wr_data,
  // Request channel.
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_op,
  input  logic [bsfn_pkg::ELEM_W-1:0]  in_elem,
  // Result channel.
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic                         out_is_member,
  output logic                         out_next_found,
  output logic [bsfn_pkg::ELEM_W-1:0]  out_next_index,
  output logic [bsfn_pkg::CNT_W-1:0]   out_member_total,
  output logic                         out_is_empty
);

  localparam int WORD_BITS = bsfn_pkg::WORD_BITS;
  localparam int NUM_WORDS = bsfn_pkg::NUM_WORDS;
  localparam int WORD_W    = bsfn_pkg::WORD_W;
  localparam int ADDR_W    = bsfn_pkg::ADDR_W;
  localparam int ELEM_W    = bsfn_pkg::ELEM_W;
  localparam int CAP_W     = bsfn_pkg::CAP_W;
  localparam int CNT_W     = bsfn_pkg::CNT_W;

  bsfn_pkg::state_t state_r, state_nxt;
  bsfn_pkg::op_t    op_r, op_nxt;

  logic [ELEM_W-1:0]    elem_r, elem_nxt;
  logic [CAP_W-1:0]     lim_r, lim_nxt;
  logic [ADDR_W-1:0]    last_w_r, last_w_nxt;
  logic [ADDR_W-1:0]    ptr_r, ptr_nxt;
  logic                 first_r, first_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [NUM_WORDS-1:0] row_valid_r, row_valid_nxt;
  logic [CAP_W-1:0]     cap_r;

  logic                 res_status_r, res_status_nxt;
  logic                 res_member_r, res_member_nxt;
  logic                 res_found_r, res_found_nxt;
  logic [ELEM_W-1:0]    res_index_r, res_index_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_status_r, out_status_nxt;
  logic                 out_is_member_r, out_is_member_nxt;
  logic                 out_next_found_r, out_next_found_nxt;
  logic [ELEM_W-1:0]    out_next_index_r, out_next_index_nxt;
  logic [CNT_W-1:0]     out_member_total_r, out_member_total_nxt;
  logic                 out_is_empty_r, out_is_empty_nxt;

  // RAM port signals.
  logic                 ram_wr_en;
  logic [WORD_BITS-1:0] ram_wr_data;
  logic                 ram_rd_en;
  logic [ADDR_W-1:0]    ram_rd_addr;
  logic [WORD_BITS-1:0] ram_rd_data;

  // Word unit signals.
  logic [WORD_BITS-1:0] word;
  logic [WORD_W-1:0]    bit_pos;
  logic [WORD_BITS-1:0] bit_mask;
  logic                 present;
  logic [WORD_W-1:0]    scan_start;
  logic                 scan_any;
  logic [WORD_W-1:0]    scan_pos;
  logic [ELEM_W-1:0]    found_idx;

  // Effective limit for a new request: capacity clamped to the bitmap size.
  logic [CAP_W-1:0]     in_lim;
  logic [CAP_W-1:0]     in_lim_m1;
  logic                 accept;

  assign in_lim    = (cap_r > CAP_W'(bsfn_pkg::MAX_ELEMENTS)) ?
                     CAP_W'(bsfn_pkg::MAX_ELEMENTS) : cap_r;
  assign in_lim_m1 = in_lim - CAP_W'(1);
  assign in_ready  = (state_r == bsfn_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;

  bsfn_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ptr_r),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // A row that was never written reads as zero.
  assign word      = row_valid_r[ptr_r] ? ram_rd_data : '0;
  assign bit_pos   = elem_r[WORD_W-1:0];
  assign bit_mask  = WORD_BITS'(1) << bit_pos;
  assign present   = |(word & bit_mask);
  // Only the first word of a find-next is masked below the start number.
  assign scan_start = first_r ? bit_pos : '0;
  assign found_idx  = {ptr_r, scan_pos};

  bsfn_word_scan u_scan (
    .word  (word),
    .start (scan_start),
    .any   (scan_any),
    .pos   (scan_pos)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bsfn_pkg::ST_IDLE;
      count_r     <= '0;
      row_valid_r <= '0;
      cap_r       <= bsfn_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      row_valid_r <= row_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cap_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r               <= op_nxt;
    elem_r             <= elem_nxt;
    lim_r              <= lim_nxt;
    last_w_r           <= last_w_nxt;
    ptr_r              <= ptr_nxt;
    first_r            <= first_nxt;
    res_status_r       <= res_status_nxt;
    res_member_r       <= res_member_nxt;
    res_found_r        <= res_found_nxt;
    res_index_r        <= res_index_nxt;
    out_status_r       <= out_status_nxt;
    out_is_member_r    <= out_is_member_nxt;
    out_next_found_r   <= out_next_found_nxt;
    out_next_index_r   <= out_next_index_nxt;
    out_member_total_r <= out_member_total_nxt;
    out_is_empty_r     <= out_is_empty_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    elem_nxt       = elem_r;
    lim_nxt        = lim_r;
    last_w_nxt     = last_w_r;
    ptr_nxt        = ptr_r;
    first_nxt      = first_r;
    count_nxt      = count_r;
    row_valid_nxt  = row_valid_r;
    res_status_nxt = res_status_r;
    res_member_nxt = res_member_r;
    res_found_nxt  = res_found_r;
    res_index_nxt  = res_index_r;
    ram_wr_en      = 1'b0;
    ram_wr_data    = word;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = ptr_r;

    out_valid_nxt        = out_valid_r && !out_ready;
    out_status_nxt       = out_status_r;
    out_is_member_nxt    = out_is_member_r;
    out_next_found_nxt   = out_next_found_r;
    out_next_index_nxt   = out_next_index_r;
    out_member_total_nxt = out_member_total_r;
    out_is_empty_nxt     = out_is_empty_r;

    case (state_r)
      bsfn_pkg::ST_IDLE: begin
        if (accept) begin
          op_nxt         = bsfn_pkg::op_t'(in_op);
          elem_nxt       = in_elem;
          lim_nxt        = in_lim;
          last_w_nxt     = in_lim_m1[WORD_W +: ADDR_W];
          ptr_nxt        = in_elem[WORD_W +: ADDR_W];
          first_nxt      = 1'b1;
          res_status_nxt = 1'b0;
          res_member_nxt = 1'b0;
          res_found_nxt  = 1'b0;
          res_index_nxt  = '0;
          if (CAP_W'(in_elem) >= in_lim) begin
            // Refused: nothing is read or changed.
            res_status_nxt = 1'b1;
            state_nxt      = bsfn_pkg::ST_DONE;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = in_elem[WORD_W +: ADDR_W];
            state_nxt   = bsfn_pkg::ST_SCAN;
          end
        end
      end

      bsfn_pkg::ST_SCAN: begin
        state_nxt = bsfn_pkg::ST_DONE;
        case (op_r)
          bsfn_pkg::OP_INSERT: begin
            if (!present) begin
              ram_wr_en            = 1'b1;
              ram_wr_data          = word | bit_mask;
              row_valid_nxt[ptr_r] = 1'b1;
              count_nxt            = count_r + CNT_W'(1);
            end
          end
          bsfn_pkg::OP_ERASE: begin
            if (present) begin
              ram_wr_en            = 1'b1;
              ram_wr_data          = word & ~bit_mask;
              row_valid_nxt[ptr_r] = 1'b1;
              count_nxt            = count_r - CNT_W'(1);
            end
          end
          bsfn_pkg::OP_TEST: begin
            res_member_nxt = present;
          end
          bsfn_pkg::OP_FIND: begin
            if (scan_any) begin
              // The lowest set bit decides; beyond the limit it means no member.
              if (CAP_W'(found_idx) < lim_r) begin
                res_found_nxt = 1'b1;
                res_index_nxt = found_idx;
              end
            end else if (ptr_r != last_w_r) begin
              // Empty word below the last one: read the next word and stay.
              ptr_nxt     = ptr_r + ADDR_W'(1);
              first_nxt   = 1'b0;
              ram_rd_en   = 1'b1;
              ram_rd_addr = ptr_r + ADDR_W'(1);
              state_nxt   = bsfn_pkg::ST_SCAN;
            end
          end
          default: begin
            state_nxt = bsfn_pkg::ST_DONE;
          end
        endcase
      end

      bsfn_pkg::ST_DONE: begin
        // Wait for the output register to be free, then hand the result over.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_status_nxt       = res_status_r;
          out_is_member_nxt    = res_member_r;
          out_next_found_nxt   = res_found_r;
          out_next_index_nxt   = res_index_r;
          out_member_total_nxt = count_r;
          out_is_empty_nxt     = (count_r == '0);
          state_nxt            = bsfn_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bsfn_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_is_member    = out_is_member_r;
  assign out_next_found   = out_next_found_r;
  assign out_next_index   = out_next_index_r;
  assign out_member_total = out_member_total_r;
  assign out_is_empty     = out_is_empty_r;

endmodule

FILE: hw/rtl/bsfn_chk.sv
// Port-level checker for the bitmap block, bound to the top level.
// Depends on bsfn_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bsfn_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic                         out_is_member,
  input logic                         out_next_found,
  input logic [bsfn_pkg::ELEM_W-1:0]  out_next_index,
  input logic [bsfn_pkg::CNT_W-1:0]   out_member_total,
  input logic                         out_is_empty
);

  // A held result stays valid and keeps its count and index until taken.
  `BSFN_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_member_total) && $stable(out_next_index), "result changed while stalled")

  // The empty flag follows the reported count.
  `BSFN_ASSERT_IMP(a_empty_flag, clk, rst_n, out_valid, out_is_empty == (out_member_total == '0), "empty flag disagrees with count")

  // A refused word carries no query answer.
  `BSFN_ASSERT_IMP(a_refused_clean, clk, rst_n, out_valid && out_status, !out_is_member && !out_next_found && (out_next_index == '0), "refused word has query bits")

  // The count never exceeds the bitmap size.
  `BSFN_ASSERT_IMP(a_count_bound, clk, rst_n, out_valid, out_member_total <= bsfn_pkg::CNT_W'(bsfn_pkg::MAX_ELEMENTS), "member count out of range")

  // One word is worked on at a time.
  `BSFN_ASSERT_NXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready, "input ready right after accept")

endmodule

bind bitmap_set_find_next bsfn_chk u_bsfn_chk (.*);

FILE: tb/bitmap_set_find_next_test.sv
// Testbench for the membership bitmap with find-next (bitmap_set_find_next).
// Depends on bsfn_pkg and the RTL of the block; a shadow bitmap predicts each reply.
`timescale 1ns / 1ps

module bitmap_set_find_next_test;

  // Run length and pacing.
  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 11;
  localparam int MAX_GAP      = 12;
  localparam int HOLD_CYCLES  = 300;
  // Find-next may read all sixteen words before its result is handed over.
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 1000000;

  // One reply word as the block reports it.
  typedef struct packed {
    logic                        status;
    logic                        is_member;
    logic                        next_found;
    logic [bsfn_pkg::ELEM_W-1:0] next_index;
    logic [bsfn_pkg::CNT_W-1:0]  member_total;
    logic                        is_empty;
  } set_reply_t;

  logic                        clk;
  logic                        rst_n;
  logic                        cfg_wr_en;
  logic [bsfn_pkg::CAP_W-1:0]  cfg_wr_data;
  logic                        in_valid;
  logic                        in_ready;
  logic [1:0]                  in_op;
  logic [bsfn_pkg::ELEM_W-1:0] in_elem;
  logic                        out_valid;
  logic                        out_ready;
  logic                        out_status;
  logic                        out_is_member;
  logic                        out_next_found;
  logic [bsfn_pkg::ELEM_W-1:0] out_next_index;
  logic [bsfn_pkg::CNT_W-1:0]  out_member_total;
  logic                        out_is_empty;

  // Shadow copy of the block's state and of its capacity register.
  logic [bsfn_pkg::MAX_ELEMENTS-1:0] shadow_members;
  int unsigned                       shadow_count;
  logic [bsfn_pkg::CAP_W-1:0]        shadow_capacity;

  // Replies predicted at input accept, oldest first.
  set_reply_t predicted_replies[$];

  int error_count;
  int reply_number;
  int cycle_count;

  // Pacing controls shared by the sender and the receiver.
  bit idle_on;
  bit stall_on;
  bit hold_request;

  bitmap_set_find_next i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_elem          (in_elem),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_is_member    (out_is_member),
    .out_next_found   (out_next_found),
    .out_next_index   (out_next_index),
    .out_member_total (out_member_total),
    .out_is_empty     (out_is_empty)
  );

  // 20 ns clock, starting low.
  initial clk = 1'b0;
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d replies still awaited",
               cycle_count, predicted_replies.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Applies one request to the shadow bitmap and returns the reply it should cause.
  // The effective limit is the capacity clamped to the bitmap size; anything at or
  // above it is refused and leaves the state alone, but still reports the count.
  function automatic set_reply_t apply_to_shadow_set(bsfn_pkg::op_t op,
                                                     logic [bsfn_pkg::ELEM_W-1:0] elem);
    set_reply_t  r;
    int unsigned lim;
    int unsigned n;
    r   = '0;
    lim = (shadow_capacity < bsfn_pkg::MAX_ELEMENTS) ? shadow_capacity
                                                     : bsfn_pkg::MAX_ELEMENTS;
    if (elem >= lim) begin
      r.status = 1'b1;
    end else begin
      case (op)
        bsfn_pkg::OP_INSERT: begin
          if (!shadow_members[elem]) begin
            shadow_members[elem] = 1'b1;
            shadow_count++;
          end
        end
        bsfn_pkg::OP_ERASE: begin
          if (shadow_members[elem]) begin
            shadow_members[elem] = 1'b0;
            shadow_count--;
          end
        end
        bsfn_pkg::OP_TEST: begin
          r.is_member = shadow_members[elem];
        end
        default: begin
          // Lowest member at or above the start, stopping at the limit even when
          // members are stored above it.
          for (n = elem; n < lim && !r.next_found; n++) begin
            if (shadow_members[n]) begin
              r.next_found = 1'b1;
              r.next_index = bsfn_pkg::ELEM_W'(n);
            end
          end
        end
      endcase
    end
    r.member_total = bsfn_pkg::CNT_W'(shadow_count);
    r.is_empty     = (shadow_count == 0);
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    $display("Mismatch in reply %0d, %s: got %0d, expected %0d",
             reply_number, field, got, want);
    error_count++;
  endtask

  // Offers one request word, after a random gap while idle_on is set, and predicts its reply on accept.
  // Valid is left high on return: the next call either replaces the payload at the
  // next falling edge or lowers valid there, so it is never dropped and raised in
  // one time step.
  task automatic send_request(input bsfn_pkg::op_t op,
                              input logic [bsfn_pkg::ELEM_W-1:0] elem);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_op    <= op;
    in_elem  <= elem;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted_replies.push_back(apply_to_shadow_set(op, elem));
  endtask

  // Drops valid and waits until every reply is in, then waits out a drain margin
  // before anything else happens.
  task automatic wait_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (predicted_replies.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Capacity is only written with the block idle.
  task automatic set_capacity(input logic [bsfn_pkg::CAP_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk) cfg_wr_en <= 1'b0;
    shadow_capacity = value;
  endtask

  // Random request: element numbers mostly below the limit so that requests do
  // real work, with some spread over the whole field to hit refusals.
  task automatic send_random_request(input int insert_pct);
    bsfn_pkg::op_t               op;
    logic [bsfn_pkg::ELEM_W-1:0] elem;
    int unsigned                 lim;
    int                          pick;
    lim  = (shadow_capacity < bsfn_pkg::MAX_ELEMENTS) ? shadow_capacity
                                                      : bsfn_pkg::MAX_ELEMENTS;
    pick = $urandom_range(0, 99);
    if (pick < insert_pct)
      op = bsfn_pkg::OP_INSERT;
    else if (pick < insert_pct + (100 - insert_pct) / 3)
      op = bsfn_pkg::OP_ERASE;
    else if (pick < insert_pct + 2 * (100 - insert_pct) / 3)
      op = bsfn_pkg::OP_TEST;
    else
      op = bsfn_pkg::OP_FIND;
    if (lim > 0 && $urandom_range(0, 99) < 85)
      elem = bsfn_pkg::ELEM_W'($urandom_range(0, lim - 1));
    else
      elem = bsfn_pkg::ELEM_W'($urandom_range(0, bsfn_pkg::MAX_ELEMENTS - 1));
    send_request(op, elem);
  endtask

  // Receiver: draws a stall per reply while stall_on is set and, when asked, holds off for a long stretch
  // so that the output register and the pipeline fill and the input stalls.
  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = stall_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        @(negedge clk) out_ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Reply checker: every accepted reply word is compared with the oldest prediction.
  always @(posedge clk) begin
    set_reply_t want;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_replies.size() == 0) begin
        $display("Reply %0d arrived with no request outstanding", reply_number);
        error_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", out_status, want.status);
        if (out_is_member !== want.is_member)
          report_mismatch("is_member", out_is_member, want.is_member);
        if (out_next_found !== want.next_found)
          report_mismatch("next_found", out_next_found, want.next_found);
        if (out_next_index !== want.next_index)
          report_mismatch("next_index", out_next_index, want.next_index);
        if (out_member_total !== want.member_total)
          report_mismatch("member_total", out_member_total, want.member_total);
        if (out_is_empty !== want.is_empty)
          report_mismatch("is_empty", out_is_empty, want.is_empty);
      end
      reply_number++;
    end
  end

  // Directed requests at the reset capacity: empty set, both ends of the element
  // range, duplicate insert, erase of an absent element, and find-next across a
  // word boundary and at the very last element.
  task automatic test_directed_requests();
    idle_on  = 1'b1;
    stall_on = 1'b1;
    send_request(bsfn_pkg::OP_FIND,   10'd0);
    send_request(bsfn_pkg::OP_TEST,   10'd0);
    send_request(bsfn_pkg::OP_INSERT, 10'd0);
    send_request(bsfn_pkg::OP_INSERT, 10'd1023);
    send_request(bsfn_pkg::OP_INSERT, 10'd0);
    send_request(bsfn_pkg::OP_TEST,   10'd0);
    send_request(bsfn_pkg::OP_TEST,   10'd1023);
    send_request(bsfn_pkg::OP_TEST,   10'd5);
    send_request(bsfn_pkg::OP_FIND,   10'd0);
    send_request(bsfn_pkg::OP_FIND,   10'd1);
    send_request(bsfn_pkg::OP_FIND,   10'd1023);
    send_request(bsfn_pkg::OP_ERASE,  10'd5);
    send_request(bsfn_pkg::OP_ERASE,  10'd0);
    send_request(bsfn_pkg::OP_FIND,   10'd0);
    send_request(bsfn_pkg::OP_INSERT, 10'd63);
    send_request(bsfn_pkg::OP_INSERT, 10'd64);
    send_request(bsfn_pkg::OP_FIND,   10'd1);
    send_request(bsfn_pkg::OP_FIND,   10'd64);
    send_request(bsfn_pkg::OP_ERASE,  10'd1023);
    send_request(bsfn_pkg::OP_FIND,   10'd65);
    send_request(bsfn_pkg::OP_ERASE,  10'd63);
    send_request(bsfn_pkg::OP_ERASE,  10'd64);
    send_request(bsfn_pkg::OP_TEST,   10'd64);
  endtask

  // Capacity edges: zero refuses everything, one admits only element 0, the
  // largest register value is clamped, and a lowered capacity hides members that
  // still count.
  task automatic test_capacity_edges();
    set_capacity(bsfn_pkg::CAP_W'(0));
    send_request(bsfn_pkg::OP_INSERT, 10'd0);
    send_request(bsfn_pkg::OP_FIND,   10'd0);
    set_capacity(bsfn_pkg::CAP_W'(1));
    send_request(bsfn_pkg::OP_INSERT, 10'd0);
    send_request(bsfn_pkg::OP_INSERT, 10'd1);
    send_request(bsfn_pkg::OP_FIND,   10'd0);
    set_capacity(bsfn_pkg::CAP_W'(2047));
    send_request(bsfn_pkg::OP_INSERT, 10'd1023);
    send_request(bsfn_pkg::OP_INSERT, 10'd700);
    send_request(bsfn_pkg::OP_FIND,   10'd1);
    set_capacity(bsfn_pkg::CAP_W'(100));
    send_request(bsfn_pkg::OP_FIND,   10'd50);
    send_request(bsfn_pkg::OP_TEST,   10'd1023);
    send_request(bsfn_pkg::OP_ERASE,  10'd700);
    send_request(bsfn_pkg::OP_TEST,   10'd99);
    set_capacity(bsfn_pkg::CAP_W'(1024));
    send_request(bsfn_pkg::OP_FIND,   10'd50);
    send_request(bsfn_pkg::OP_ERASE,  10'd700);
  endtask

  // Long receiver hold-off while the sender keeps offering requests back to back.
  task automatic test_output_hold_off();
    idle_on      = 1'b0;
    hold_request = 1'b1;
    repeat (16) send_random_request(50);
    wait_idle();
  endtask

  // Random traffic in phases, each with its own capacity and insert bias so the
  // set runs both sparse and dense. Pacing changes in stretches of forty requests.
  task automatic test_random_traffic();
    logic [bsfn_pkg::CAP_W-1:0] caps [9];
    int                         counts [9];
    int                         p;
    int                         k;
    int                         insert_pct;
    caps   = '{bsfn_pkg::CAP_W'(1024), bsfn_pkg::CAP_W'(64), bsfn_pkg::CAP_W'(2047),
               bsfn_pkg::CAP_W'(65), bsfn_pkg::CAP_W'(1000),
               bsfn_pkg::CAP_W'($urandom_range(2, 1023)), bsfn_pkg::CAP_W'(1),
               bsfn_pkg::CAP_W'(0), bsfn_pkg::CAP_W'(1024)};
    counts = '{200, 200, 220, 200, 200, 200, 60, 30, 330};
    for (p = 0; p < 9; p++) begin
      set_capacity(caps[p]);
      insert_pct = $urandom_range(20, 60);
      for (k = 0; k < counts[p]; k++) begin
        if (k % 40 == 0) begin
          idle_on  = ($urandom_range(0, 3) != 0);
          stall_on = ($urandom_range(0, 3) != 0);
        end
        send_random_request(insert_pct);
      end
    end
  endtask

  initial begin
    shadow_members  = '0;
    shadow_count    = 0;
    shadow_capacity = bsfn_pkg::CAP_RESET;
    error_count     = 0;
    reply_number    = 0;
    cycle_count     = 0;
    idle_on         = 1'b0;
    stall_on        = 1'b0;
    hold_request    = 1'b0;
    rst_n           = 1'b0;
    cfg_wr_en       = 1'b0;
    cfg_wr_data     = '0;
    in_valid        = 1'b0;
    in_op           = bsfn_pkg::OP_INSERT;
    in_elem         = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_directed_requests();
    test_capacity_edges();
    test_output_hold_off();
    test_random_traffic();

    wait_idle();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/bsfn_pkg.sv
hw/rtl/bsfn_ram.sv
hw/rtl/bsfn_word_scan.sv
hw/rtl/bitmap_set_find_next.sv
hw/rtl/bsfn_chk.sv
tb/bitmap_set_find_next_test.sv
